FILE: hw/rtl/rmst_pkg.sv
// Shared types and constants for the range-minimum segment tree.
`default_nettype none
package rmst_pkg;

    // Tree geometry: leaves sit at C_LEAVES .. 2*C_LEAVES-1, node 1 is the root
    localparam int C_LEAVES = 1024;
    localparam int C_LW     = $clog2(C_LEAVES);     // element index width
    localparam int C_AW     = C_LW + 1;             // tree node address width
    localparam int C_QW     = C_AW + 1;             // query bound width (holds 2*C_LEAVES)
    localparam int C_CNT_W  = 11;                   // element count register width
    localparam int C_VAL_W  = 32;

    localparam logic signed [C_VAL_W-1:0] C_MIN_ID = 32'sh7FFF_FFFF;

    // Request kinds
    localparam logic C_REQ_UPDATE = 1'b0;
    localparam logic C_REQ_QUERY  = 1'b1;

    // Response status codes
    localparam logic C_ST_OK    = 1'b0;
    localparam logic C_ST_RANGE = 1'b1;

    typedef enum logic [2:0] {
        S_CLR,      // sweep the tree store to the identity
        S_IDLE,     // wait for a request
        S_UPW,      // write current node, read its sibling
        S_UPC,      // fold sibling into running minimum, climb
        S_QLO,      // fold high-side read, issue low-side read
        S_QHI,      // fold low-side read, issue high-side read, shift bounds
        S_OUT       // hand the result to the output register
    } t_state;

    typedef struct packed {
        logic                      req_type;
        logic [9:0]                elem_index;
        logic signed [C_VAL_W-1:0] new_value;
        logic [9:0]                range_low;
        logic [9:0]                range_high;
    } t_req;

    typedef struct packed {
        logic signed [C_VAL_W-1:0] min_value;
        logic                      status;
    } t_rsp;

endpackage
`default_nettype wire

FILE: hw/rtl/rmst_if.sv
// Valid/ready channel interfaces for requests, responses and configuration.
`default_nettype none
interface rmst_req_if;
    import rmst_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rmst_rsp_if;
    import rmst_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rmst_cfg_if;
    import rmst_pkg::*;
    logic               valid;
    logic               ready;
    logic [C_CNT_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/range_min_segment_tree.sv
// Range-minimum segment tree with point updates, one shared compare unit.
//
//  channel | dir | payload                                            | handshake
//  i_req   | in  | req_type, elem_index, new_value, range_low/high    | valid/ready
//  o_rsp   | out | min_value, status                                  | valid/ready
//  i_cfg   | in  | element_count (11 bits)                            | valid/ready
//
// An update writes each node on its path and reads its sibling, then folds the
// sibling in and climbs, ending with the root write and a hand off. A query folds
// low-side and high-side nodes per level, then a closing check and hand off;
// the tree store has one read port and the min compare is shared by all steps.
// After reset a clearing pass writes all 2048 nodes, one a cycle; no request is
// taken until that pass ends. A stalled response waits in the output register
// while the next request runs; a finished request waits until that slot frees.
`default_nettype none
module range_min_segment_tree (
    input  wire       i_clk,
    input  wire       i_rst_n,
    rmst_req_if.sink  i_req,
    rmst_rsp_if.source o_rsp,
    rmst_cfg_if.sink  i_cfg
);
    import rmst_pkg::*;

    // Tree store
    logic signed [C_VAL_W-1:0] r_tree [2*C_LEAVES];
    logic signed [C_VAL_W-1:0] r_rd;

    t_state r_state, n_state;

    logic [C_AW-1:0]           r_clr, n_clr;
    logic [C_AW-1:0]           r_idx, n_idx;
    logic signed [C_VAL_W-1:0] r_acc, n_acc;
    logic signed [C_VAL_W-1:0] r_echo, n_echo;
    logic                      r_upd, n_upd;
    logic [C_QW-1:0]           r_lo, n_lo;
    logic [C_QW-1:0]           r_hi, n_hi;
    logic                      r_fa, n_fa;
    logic                      r_fb, n_fb;
    logic                      r_status, n_status;
    logic [C_CNT_W-1:0]        r_count;
    logic                      r_out_valid;
    t_rsp                      r_out;

    logic                      w_mem_we;
    logic [C_AW-1:0]           w_mem_wa;
    logic signed [C_VAL_W-1:0] w_mem_wd;
    logic [C_AW-1:0]           w_mem_ra;

    logic [C_CNT_W-1:0]        w_count;
    logic [C_CNT_W-1:0]        w_hi_clip;
    logic                      w_upd_ok;
    logic                      w_q_empty;
    logic signed [C_VAL_W-1:0] w_min;
    logic                      w_accept;
    logic                      w_out_free;
    logic [C_QW-1:0]           w_hi_dec;

    // Shared compare unit: running minimum against the registered read data
    assign w_min = (r_rd < r_acc) ? r_rd : r_acc;

    // Active element count saturates at the leaf count
    assign w_count = (r_count > C_CNT_W'(C_LEAVES)) ? C_CNT_W'(C_LEAVES) : r_count;

    // Request decode
    assign w_upd_ok  = C_CNT_W'(i_req.data.elem_index) < w_count;
    assign w_hi_clip = (C_CNT_W'(i_req.data.range_high) >= w_count) ?
                       (w_count - C_CNT_W'(1)) : C_CNT_W'(i_req.data.range_high);
    assign w_q_empty = (w_count == '0) || (C_CNT_W'(i_req.data.range_low) > w_hi_clip);

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_hi_dec    = r_hi - C_QW'(1);

    // Configuration is always taken
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR: begin
                if (r_clr == {C_AW{1'b1}}) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req.data.req_type == C_REQ_UPDATE) begin
                        n_state = w_upd_ok ? S_UPW : S_OUT;
                    end else begin
                        n_state = w_q_empty ? S_OUT : S_QLO;
                    end
                end
            end
            S_UPW: begin
                n_state = (r_idx == C_AW'(1)) ? S_OUT : S_UPC;
            end
            S_UPC: n_state = S_UPW;
            S_QLO: begin
                n_state = (r_lo >= r_hi) ? S_OUT : S_QHI;
            end
            S_QHI: n_state = S_QLO;
            S_OUT: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        n_clr    = r_clr;
        n_idx    = r_idx;
        n_acc    = r_acc;
        n_echo   = r_echo;
        n_upd    = r_upd;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_fa     = r_fa;
        n_fb     = r_fb;
        n_status = r_status;
        w_mem_we = 1'b0;
        w_mem_wa = r_idx;
        w_mem_wd = r_acc;
        w_mem_ra = r_idx ^ C_AW'(1);
        case (r_state)
            S_CLR: begin
                w_mem_we = 1'b1;
                w_mem_wa = r_clr;
                w_mem_wd = C_MIN_ID;
                n_clr    = r_clr + C_AW'(1);
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req.data.req_type == C_REQ_UPDATE) begin
                        // Keep the written value to echo it back
                        n_acc    = i_req.data.new_value;
                        n_echo   = i_req.data.new_value;
                        n_upd    = 1'b1;
                        n_idx    = C_AW'(C_LEAVES) + C_AW'(i_req.data.elem_index);
                        n_status = w_upd_ok ? C_ST_OK : C_ST_RANGE;
                    end else begin
                        n_acc    = C_MIN_ID;
                        n_upd    = 1'b0;
                        n_status = C_ST_OK;
                        n_fb     = 1'b0;
                        n_lo     = C_QW'(C_LEAVES) + C_QW'(i_req.data.range_low);
                        n_hi     = C_QW'(C_LEAVES) + C_QW'(w_hi_clip) + C_QW'(1);
                    end
                end
            end
            S_UPW: begin
                // Write the node on the path, fetch its sibling
                w_mem_we = 1'b1;
                w_mem_wa = r_idx;
                w_mem_wd = r_acc;
                w_mem_ra = r_idx ^ C_AW'(1);
            end
            S_UPC: begin
                n_acc = w_min;
                n_idx = r_idx >> 1;
            end
            S_QLO: begin
                // Fold the pending high-side node, fetch the low-side one
                if (r_fb) n_acc = w_min;
                w_mem_ra = r_lo[C_AW-1:0];
                n_fa     = r_lo[0];
                n_lo     = r_lo + C_QW'(r_lo[0]);
            end
            S_QHI: begin
                // Fold the low-side node, fetch the high-side one, climb a level
                if (r_fa) n_acc = w_min;
                w_mem_ra = w_hi_dec[C_AW-1:0];
                n_fb     = r_hi[0];
                n_lo     = r_lo >> 1;
                n_hi     = (r_hi - C_QW'(r_hi[0])) >> 1;
            end
            S_OUT: ;
            default: ;
        endcase
    end

    // Tree store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_tree[w_mem_wa] <= w_mem_wd;
        r_rd <= r_tree[w_mem_ra];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_count     <= C_CNT_W'(C_LEAVES);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            if (i_cfg.valid && i_cfg.ready) r_count <= i_cfg.data;
            // Load the output slot when the result is ready, drop it when taken
            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_acc    <= n_acc;
        r_echo   <= n_echo;
        r_upd    <= n_upd;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_fa     <= n_fa;
        r_fb     <= n_fb;
        r_status <= n_status;
        if (r_state == S_OUT && w_out_free) begin
            r_out.min_value <= r_upd ? r_echo : r_acc;
            r_out.status    <= r_status;
        end
    end

    // An accepted request always starts work
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("request accepted but sequencer stayed idle");

    // Query bounds never cross while walking
    a_query_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QHI) |-> (r_lo <= r_hi))
        else $error("query bounds crossed");

    // Update walk never reaches the unused node zero
    a_update_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPW || r_state == S_UPC) |-> (r_idx != '0))
        else $error("update walk reached node zero");

    // An out-of-range status only follows a rejected update
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPC) |-> (r_status == C_ST_OK))
        else $error("update walk running with range error status");

endmodule
`default_nettype wire

FILE: verif/rmst_min_checker.sv
// Checker for the range-minimum segment tree: mirrors the tree, predicts and compares responses.
module rmst_min_checker
    import rmst_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    rmst_req_if  req_mon,
    rmst_rsp_if  rsp_mon,
    rmst_cfg_if  cfg_mon,
    output int   o_mismatches,
    output int   o_outstanding
);

    // Mirror of the minima tree: node 1 is the root, leaves at C_LEAVES and up
    logic signed [C_VAL_W-1:0] min_tree [1:2*C_LEAVES-1];
    logic [C_CNT_W-1:0]        elem_count;
    t_rsp                      expected_rsps [$];
    int                        mismatch_cnt = 0;

    function automatic logic signed [C_VAL_W-1:0] smaller(
        input logic signed [C_VAL_W-1:0] a,
        input logic signed [C_VAL_W-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

    // Apply one request to the mirror and work out the response it owes
    function automatic t_rsp answer_request(input t_req r);
        t_rsp ans;
        int   live;
        int   node;
        int   lo;
        int   hi;
        live       = (int'(elem_count) > C_LEAVES) ? C_LEAVES : int'(elem_count);
        ans.status = C_ST_OK;
        if (r.req_type == C_REQ_UPDATE) begin
            ans.min_value = r.new_value;
            if (int'(r.elem_index) >= live) begin
                ans.status = C_ST_RANGE;
            end else begin
                // write the leaf, then refold every ancestor up to the root
                node           = C_LEAVES + int'(r.elem_index);
                min_tree[node] = r.new_value;
                while (node > 1) begin
                    node           = node / 2;
                    min_tree[node] = smaller(min_tree[2*node], min_tree[2*node+1]);
                end
            end
        end else begin
            ans.min_value = C_MIN_ID;
            lo            = int'(r.range_low);
            hi            = int'(r.range_high);
            // clip the top of the range to the live elements
            if (hi >= live) hi = live - 1;
            if (live > 0 && lo <= hi) begin
                // half-open bottom-up walk over [lo, hi+1)
                lo = lo + C_LEAVES;
                hi = hi + C_LEAVES + 1;
                while (lo < hi) begin
                    if (lo % 2 == 1) begin
                        ans.min_value = smaller(ans.min_value, min_tree[lo]);
                        lo++;
                    end
                    if (hi % 2 == 1) begin
                        hi--;
                        ans.min_value = smaller(ans.min_value, min_tree[hi]);
                    end
                    lo = lo / 2;
                    hi = hi / 2;
                end
            end
        end
        return ans;
    endfunction

    // Track every transaction on the three channels
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            for (int n = 1; n < 2*C_LEAVES; n++) min_tree[n] = C_MIN_ID;
            elem_count = C_CNT_W'(C_LEAVES);
            expected_rsps.delete();
        end else begin
            // retire a response against the oldest prediction
            if (rsp_mon.valid && rsp_mon.ready) begin
                if (expected_rsps.size() == 0) begin
                    $display("%0t: unexpected response, actual min_value=%0d status=%0d",
                             $time, rsp_mon.data.min_value, rsp_mon.data.status);
                    mismatch_cnt++;
                end else begin
                    want = expected_rsps.pop_front();
                    if (rsp_mon.data.min_value !== want.min_value) begin
                        $display("%0t: min_value mismatch, expected %0d actual %0d",
                                 $time, want.min_value, rsp_mon.data.min_value);
                        mismatch_cnt++;
                    end
                    if (rsp_mon.data.status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, want.status, rsp_mon.data.status);
                        mismatch_cnt++;
                    end
                end
            end
            // latch a new element count
            if (cfg_mon.valid && cfg_mon.ready) elem_count = cfg_mon.data;
            // predict the response of an accepted request, queue it at the tail
            if (req_mon.valid && req_mon.ready) begin
                expected_rsps.insert(expected_rsps.size(), answer_request(req_mon.data));
            end
        end
        o_outstanding <= expected_rsps.size();
        o_mismatches  <= mismatch_cnt;
    end

endmodule

FILE: verif/tb.sv
// Testbench top for the range-minimum segment tree: stimulus, response stalls and verdict.
module tb;
    import rmst_pkg::*;

    localparam int C_IDLE_LIMIT = 8000;
    localparam int C_HOLD_OFF   = 400;
    localparam int C_PHASE_LEN  = 250;
    localparam int C_REQ_W      = $bits(t_req);

    logic clk = 1'b0;
    logic rst_n;
    int   outstanding;
    int   mismatches;
    int   burst_left = 0;
    int   idle_cycles = 0;
    logic hold_armed = 1'b0;

    rmst_req_if req_ch ();
    rmst_rsp_if rsp_ch ();
    rmst_cfg_if cfg_ch ();

    range_min_segment_tree dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    rmst_min_checker checker_0 (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .req_mon       (req_ch),
        .rsp_mon       (rsp_ch),
        .cfg_mon       (cfg_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Abort when no transaction moves for too long
    always @(posedge clk) begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= C_IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic t_req make_update(input int idx, input logic signed [31:0] v);
        t_req r;
        r            = t_req'(C_REQ_W'({$urandom, $urandom}));
        r.req_type   = C_REQ_UPDATE;
        r.elem_index = 10'(idx);
        r.new_value  = v;
        return r;
    endfunction

    function automatic t_req make_query(input int lo, input int hi);
        t_req r;
        r            = t_req'(C_REQ_W'({$urandom, $urandom}));
        r.req_type   = C_REQ_QUERY;
        r.range_low  = 10'(lo);
        r.range_high = 10'(hi);
        return r;
    endfunction

    // Random request, mostly aimed at the live part of the array
    function automatic t_req rand_req(input int live);
        t_req r;
        int   a;
        int   b;
        r.req_type   = ($urandom_range(0, 9) < 4) ? C_REQ_UPDATE : C_REQ_QUERY;
        r.elem_index = 10'($urandom);
        r.range_low  = 10'($urandom);
        r.range_high = 10'($urandom);
        case ($urandom_range(0, 7))
            0:       r.new_value = C_MIN_ID;
            1:       r.new_value = {1'b1, 31'd0};
            2, 3:    r.new_value = int'($urandom_range(0, 40)) - 20;
            default: r.new_value = $urandom;
        endcase
        if (live > 0 && $urandom_range(0, 9) != 0) begin
            a            = $urandom_range(0, live - 1);
            b            = $urandom_range(0, live - 1);
            r.elem_index = 10'(a);
            case ($urandom_range(0, 5))
                // narrow window that may run past the count
                0: begin
                    r.range_low  = 10'(a);
                    r.range_high = 10'(a + int'($urandom_range(0, 3)));
                end
                // reversed bounds
                1: begin
                    r.range_low  = 10'((a > b) ? a : b);
                    r.range_high = 10'((a > b) ? b : a);
                end
                // whole array, clipped by the count
                2: begin
                    r.range_low  = '0;
                    r.range_high = 10'd1023;
                end
                default: begin
                    r.range_low  = 10'((a < b) ? a : b);
                    r.range_high = 10'((a < b) ? b : a);
                end
            endcase
        end
        return r;
    endfunction

    // Offer one request in bursts with random gaps, hold until accepted
    task automatic offer(input t_req r);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        burst_left--;
    endtask

    // Stop offering and wait for every predicted response
    task automatic settle();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    // Write the element count once the block has gone quiet
    task automatic write_count(input logic [C_CNT_W-1:0] v);
        settle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Response sink: random stall patterns plus one long hold-off
    initial begin : rsp_sink
        int   mode;
        int   span;
        logic hold_done;
        hold_done = 1'b0;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 60);
            for (int k = 0; k < span; k++) begin
                if (hold_armed && !hold_done) begin
                    rsp_ch.ready <= 1'b0;
                    repeat (C_HOLD_OFF) @(posedge clk);
                    hold_done = 1'b1;
                end
                case (mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                    2:       rsp_ch.ready <= ($urandom_range(0, 7) != 0);
                    default: rsp_ch.ready <= (k % 4 == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // Stimulus: directed corner cases, then random phases over several counts
    initial begin : stimulus
        int phase_counts [8];
        int live;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        rst_n        <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // empty tree, extremes at both ends, reversed range, overwrite
        offer(make_query(0, 1023));
        offer(make_update(0, 32'sh8000_0000));
        offer(make_update(1023, C_MIN_ID));
        offer(make_update(512, 0));
        offer(make_update(511, -1));
        offer(make_query(0, 1023));
        offer(make_query(1, 1023));
        offer(make_query(512, 1023));
        offer(make_query(1023, 1023));
        offer(make_query(600, 400));
        offer(make_update(511, 5));
        offer(make_query(1, 1022));

        // zero count: every update flagged, every query empty
        write_count('0);
        offer(make_update(0, 99));
        offer(make_query(0, 1023));

        // count above the leaf total saturates
        write_count('1);
        offer(make_update(1023, -7));
        offer(make_query(1000, 1023));

        // shrink: out-of-range update, clipped query, low above clipped high
        write_count(C_CNT_W'(4));
        offer(make_update(4, 1));
        offer(make_update(3, 3));
        offer(make_query(0, 1023));
        offer(make_query(1, 1023));
        offer(make_query(5, 9));

        phase_counts    = '{1024, 2047, 1, 0, 37, 1000, 2, 0};
        phase_counts[7] = $urandom_range(3, 1023);
        for (int p = 0; p < 8; p++) begin
            write_count(C_CNT_W'(phase_counts[p]));
            live = (phase_counts[p] > C_LEAVES) ? C_LEAVES : phase_counts[p];
            for (int k = 0; k < C_PHASE_LEN; k++) begin
                if (p == 0 && k == 100) hold_armed <= 1'b1;
                offer(rand_req(live));
            end
        end

        settle();
        repeat (60) @(posedge clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
